### sv/lcdmts_pkg.sv
// ----------------------------------------------------------------------------
// lcdmts_pkg
// shared types and constants for the lcd mode timing sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcdmts_pkg;

    // display modes as seen in the status register
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } t_mode;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_IE_VBLANK      = 3'd0;
    localparam logic [2:0] REG_IE_STAT        = 3'd1;
    localparam logic [2:0] REG_HBLANK_STAT_EN = 3'd2;
    localparam logic [2:0] REG_VBLANK_STAT_EN = 3'd3;
    localparam logic [2:0] REG_OAM_STAT_EN    = 3'd4;
    localparam logic [2:0] REG_LYC_STAT_EN    = 3'd5;
    localparam logic [2:0] REG_LYC            = 3'd6;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // mode counter saturates here
    localparam int          CLOCK_W   = 10;
    localparam logic [9:0]  CLOCK_MAX = 10'h3ff;

    // default timing
    localparam int DEF_OAM_CYCLES      = 80;
    localparam int DEF_TRANSFER_CYCLES = 172;
    localparam int DEF_HBLANK_CYCLES   = 204;
    localparam int DEF_VISIBLE_LINES   = 144;
    localparam int DEF_LAST_LINE       = 153;

    typedef struct packed {
        logic [7:0] cycle_count;
        logic       lcd_on;
    } t_tick_in;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       coincidence;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render_line;
        logic       frame_done;
    } t_tick_out;

endpackage

`default_nettype wire

### sv/lcd_mode_timing_sequencer_top.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_top
// display mode / scanline sequencer driven by elapsed-cycle ticks
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  -----------------------
//  tick in   in         i_in_valid / o_in_ready       i_in_data  (t_tick_in)
//  result    out        o_out_valid / i_out_ready     o_out_data (t_tick_out)
//  config    in         psel penable pwrite / pready  paddr pwdata prdata
//
//  one tick request per clock unless the output stalls: the new state and the
//  result are computed in the cycle the request is taken and land in the state
//  and result registers; a single result register sits on the output; a new tick
//  is taken whenever it is empty or being drained in the same cycle, so each
//  result is valid in the cycle after its tick is taken; an output stall holds
//  o_in_ready low only while the result register is full; synchronous active-low
//  reset clears the mode, line, counter, coincidence flag and all configuration registers
//
`default_nettype none

module lcd_mode_timing_sequencer_top
    import lcdmts_pkg::*;
#(
    parameter int OAM_CYCLES      = DEF_OAM_CYCLES,
    parameter int TRANSFER_CYCLES = DEF_TRANSFER_CYCLES,
    parameter int HBLANK_CYCLES   = DEF_HBLANK_CYCLES,
    parameter int VISIBLE_LINES   = DEF_VISIBLE_LINES,
    parameter int LAST_LINE       = DEF_LAST_LINE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // tick requests
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire t_tick_in           i_in_data,

    // results
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      t_tick_out          o_out_data,

    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    // thresholds in counter-compare width; anything above the saturated
    // counter value is simply never reached
    localparam logic [CLOCK_W:0] TH_OAM      = (CLOCK_W+1)'(OAM_CYCLES);
    localparam logic [CLOCK_W:0] TH_TRANSFER = (CLOCK_W+1)'(TRANSFER_CYCLES);
    localparam logic [CLOCK_W:0] TH_HBLANK   = (CLOCK_W+1)'(HBLANK_CYCLES);
    localparam logic [CLOCK_W:0] TH_LINE     =
        (CLOCK_W+1)'(OAM_CYCLES + TRANSFER_CYCLES + HBLANK_CYCLES);
    localparam logic [7:0]       VIS_LINE    = 8'(VISIBLE_LINES);
    localparam logic [8:0]       LAST_LINE9  = 9'(LAST_LINE);

    // configuration registers
    logic       r_ie_vblank;
    logic       r_ie_stat;
    logic       r_hblank_stat_en;
    logic       r_vblank_stat_en;
    logic       r_oam_stat_en;
    logic       r_lyc_stat_en;
    logic [7:0] r_lyc;

    // sequencer state
    t_mode              r_mode,  n_mode;
    logic [7:0]         r_line,  n_line;
    logic [CLOCK_W-1:0] r_clock, n_clock;
    logic               r_coin,  n_coin;

    // result register
    logic      r_out_valid;
    t_tick_out r_out, n_out;

    logic               w_in_fire;
    logic               w_cfg_wr;
    logic [2:0]         w_reg_idx;
    logic [CLOCK_W:0]   w_sum;
    logic [CLOCK_W-1:0] w_clk;
    logic [CLOCK_W:0]   w_clk_ext;
    logic [7:0]         w_line_inc;
    logic [8:0]         w_line_next9;
    logic               w_lyc_match;
    logic               w_hit_oam;
    logic               w_hit_transfer;
    logic               w_hit_hblank;
    logic               w_hit_line;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // configuration port, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie_vblank      <= 1'b0;
            r_ie_stat        <= 1'b0;
            r_hblank_stat_en <= 1'b0;
            r_vblank_stat_en <= 1'b0;
            r_oam_stat_en    <= 1'b0;
            r_lyc_stat_en    <= 1'b0;
            r_lyc            <= 8'd0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_IE_VBLANK:      r_ie_vblank      <= pwdata[0];
                REG_IE_STAT:        r_ie_stat        <= pwdata[0];
                REG_HBLANK_STAT_EN: r_hblank_stat_en <= pwdata[0];
                REG_VBLANK_STAT_EN: r_vblank_stat_en <= pwdata[0];
                REG_OAM_STAT_EN:    r_oam_stat_en    <= pwdata[0];
                REG_LYC_STAT_EN:    r_lyc_stat_en    <= pwdata[0];
                REG_LYC:            r_lyc            <= pwdata[7:0];
                default: ;          // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_IE_VBLANK:      prdata[0]   = r_ie_vblank;
            REG_IE_STAT:        prdata[0]   = r_ie_stat;
            REG_HBLANK_STAT_EN: prdata[0]   = r_hblank_stat_en;
            REG_VBLANK_STAT_EN: prdata[0]   = r_vblank_stat_en;
            REG_OAM_STAT_EN:    prdata[0]   = r_oam_stat_en;
            REG_LYC_STAT_EN:    prdata[0]   = r_lyc_stat_en;
            REG_LYC:            prdata[7:0] = r_lyc;
            default:            prdata      = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // counter update and threshold detection
    // ------------------------------------------------------------------
    // saturating add: excess past the counter range is lost
    assign w_sum     = {1'b0, r_clock} + (CLOCK_W+1)'(i_in_data.cycle_count);
    assign w_clk     = w_sum[CLOCK_W] ? CLOCK_MAX : w_sum[CLOCK_W-1:0];
    assign w_clk_ext = {1'b0, w_clk};

    assign w_hit_oam      = w_clk_ext >= TH_OAM;
    assign w_hit_transfer = w_clk_ext >= TH_TRANSFER;
    assign w_hit_hblank   = w_clk_ext >= TH_HBLANK;
    assign w_hit_line     = w_clk_ext >= TH_LINE;

    // h-blank increment wraps at 8 bits, v-blank increment does not
    assign w_line_inc   = r_line + 8'd1;
    assign w_line_next9 = {1'b0, r_line} + 9'd1;
    // compare against the upcoming line; line 255 never matches
    assign w_lyc_match  = w_line_next9 == {1'b0, r_lyc};

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_clock = w_clk;
        n_coin  = r_coin;
        if (!i_in_data.lcd_on) begin
            // display off: parked in v-blank at line 0
            n_mode  = MODE_VBLANK;
            n_line  = 8'd0;
            n_clock = '0;
        end else begin
            unique case (r_mode)
                MODE_OAM: begin
                    if (w_hit_oam) begin
                        n_mode  = MODE_TRANSFER;
                        n_clock = '0;
                    end
                end
                MODE_TRANSFER: begin
                    if (w_hit_transfer) begin
                        n_mode  = MODE_HBLANK;
                        n_clock = '0;
                        n_coin  = w_lyc_match;
                    end
                end
                MODE_HBLANK: begin
                    if (w_hit_hblank) begin
                        n_line  = w_line_inc;
                        n_clock = '0;
                        n_mode  = (w_line_inc == VIS_LINE) ? MODE_VBLANK : MODE_OAM;
                    end
                end
                MODE_VBLANK: begin
                    if (w_hit_line) begin
                        n_clock = '0;
                        if (w_line_next9 > LAST_LINE9) begin
                            // frame wrap back to the first line
                            n_mode = MODE_OAM;
                            n_line = 8'd0;
                        end else begin
                            n_line = w_line_next9[7:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result fields: pulses plus the updated state
    // ------------------------------------------------------------------
    always_comb begin
        n_out             = '0;
        n_out.mode        = n_mode;
        n_out.line        = n_line;
        n_out.coincidence = n_coin;
        if (i_in_data.lcd_on) begin
            unique case (r_mode)
                MODE_TRANSFER: begin
                    if (w_hit_transfer) begin
                        n_out.render_line = 1'b1;
                        // lyc source bypasses the ie_stat gate
                        n_out.stat_irq    = (r_ie_stat && r_hblank_stat_en) ||
                                            (w_lyc_match && r_lyc_stat_en);
                    end
                end
                MODE_HBLANK: begin
                    if (w_hit_hblank && (w_line_inc == VIS_LINE)) begin
                        n_out.frame_done = 1'b1;
                        n_out.vblank_irq = r_ie_vblank;
                        n_out.stat_irq   = r_ie_stat && r_vblank_stat_en;
                    end
                end
                MODE_VBLANK: begin
                    if (w_hit_line && (w_line_next9 > LAST_LINE9)) begin
                        n_out.stat_irq = r_ie_stat && r_oam_stat_en;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HBLANK;
            r_line      <= 8'd0;
            r_clock     <= '0;
            r_coin      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_mode  <= n_mode;
                r_line  <= n_line;
                r_clock <= n_clock;
                r_coin  <= n_coin;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
